FILE: design/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types, constants and codes of the tag presence tracker.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // table geometry and limits
  localparam int TableDepth = 16;
  localparam int MaxResults = 16;
  localparam int ResW       = $clog2(MaxResults + 1);
  localparam int InFieldW   = 5;
  localparam int PaddrW     = 3;

  // register reset values
  localparam logic [31:0] GoneTimeoutRst = 32'd1000;
  localparam logic [7:0]  RssiChangeRst  = 8'd10;

  // register indexes (paddr[2])
  localparam logic [0:0] RegGoneTimeout = 1'b0;
  localparam logic [0:0] RegRssiChange  = 1'b1;

  // result event codes
  typedef enum logic [2:0] {
    EvRefreshed   = 3'd0,
    EvArrived     = 3'd1,
    EvRssiChanged = 3'd2,
    EvGone        = 3'd3,
    EvDropped     = 3'd4,
    EvNoneGone    = 3'd5
  } event_e;

  // control states
  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StUpdate,
    StSweep
  } state_e;

  // stored entry fields that are read back
  typedef struct packed {
    logic [31:0] epc_upper;
    logic [63:0] epc_lower;
    logic [3:0]  epc_bytes;
    logic [7:0]  rssi;
  } entry_t;

  // latched request, broadcast to every cell
  typedef struct packed {
    logic [31:0] epc_upper;
    logic [63:0] epc_lower;
    logic [3:0]  epc_bytes;
    logic [7:0]  rssi;
    logic [31:0] now_ms;
  } req_t;

  // per-cell write controls
  typedef struct packed {
    logic ins;
    logic touch;
    logic set_rssi;
    logic clr;
  } cell_ctl_t;

  // one result word
  typedef struct packed {
    event_e              ev;
    logic [31:0]         tag_upper;
    logic [63:0]         tag_lower;
    logic [3:0]          tag_bytes;
    logic [7:0]          old_rssi;
    logic [7:0]          new_rssi;
    logic [InFieldW-1:0] in_field;
    logic                last;
  } res_t;

endpackage

FILE: design/tpt_in_if.sv
// ----------------------------------------------------------------------------
// tpt_in_if
// Input channel: tag report or expiry sweep word with valid/ready.
// ----------------------------------------------------------------------------
interface tpt_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [31:0]        epc_upper;
  logic [63:0]        epc_lower;
  logic [3:0]         epc_bytes;
  logic signed [7:0]  rssi_dbm;
  logic [31:0]        now_ms;

  modport source (
    output valid, mode, epc_upper, epc_lower, epc_bytes, rssi_dbm, now_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, epc_upper, epc_lower, epc_bytes, rssi_dbm, now_ms,
    output ready
  );
endinterface

FILE: design/tpt_out_if.sv
// ----------------------------------------------------------------------------
// tpt_out_if
// Output channel: event word with valid/ready.
// ----------------------------------------------------------------------------
interface tpt_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        event_res;
  logic [31:0]       tag_upper;
  logic [63:0]       tag_lower;
  logic [3:0]        tag_bytes;
  logic signed [7:0] old_rssi;
  logic signed [7:0] new_rssi;
  logic [4:0]        in_field;
  logic              last;

  modport source (
    output valid, event_res, tag_upper, tag_lower, tag_bytes, old_rssi, new_rssi,
           in_field, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, tag_upper, tag_lower, tag_bytes, old_rssi, new_rssi,
           in_field, last,
    output ready
  );
endinterface

FILE: design/tpt_cell.sv
// ----------------------------------------------------------------------------
// tpt_cell
// One table slot: holds a tag entry, matches it against the request, checks
// its age, and passes the free-slot chain and read bus on to its neighbor.
// ----------------------------------------------------------------------------
module tpt_cell
  import tpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  req_t        req_i,
  input  logic [31:0] timeout_i,
  input  logic        sel_i,
  input  logic        free_below_i,
  output logic        free_below_o,
  output logic        first_free_o,
  input  entry_t      rd_i,
  output entry_t      rd_o,
  output logic        match_o,
  output logic        expired_o,
  output logic        valid_o
);

  logic        valid_q;
  entry_t      ent_q;
  logic [31:0] seen_q;
  logic [31:0] age;

  // slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.ins) begin
      valid_q <= 1'b1;
    end else if (ctl_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      ent_q.epc_upper <= req_i.epc_upper;
      ent_q.epc_lower <= req_i.epc_lower;
      ent_q.epc_bytes <= req_i.epc_bytes;
      ent_q.rssi      <= req_i.rssi;
      seen_q          <= req_i.now_ms;
    end else if (ctl_i.touch) begin
      seen_q <= req_i.now_ms;
      if (ctl_i.set_rssi) begin
        ent_q.rssi <= req_i.rssi;
      end
    end
  end

  // key match and wrapping age check
  assign match_o = valid_q && (ent_q.epc_upper == req_i.epc_upper) &&
                   (ent_q.epc_lower == req_i.epc_lower) &&
                   (ent_q.epc_bytes == req_i.epc_bytes);
  assign age       = req_i.now_ms - seen_q;
  assign expired_o = valid_q && (age >= timeout_i);
  assign valid_o   = valid_q;

  // lowest-free chain
  assign free_below_o = free_below_i | ~valid_q;
  assign first_free_o = ~valid_q & ~free_below_i;

  // read bus: selected cell ORs its entry in
  assign rd_o = rd_i | (sel_i ? ent_q : entry_t'('0));

endmodule

FILE: design/tag_presence_tracker.sv
// ----------------------------------------------------------------------------
// tag_presence_tracker
// Table of RFID tags in the field, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per input: mode 0 is a tag report (EPC key, RSSI,
//   time), mode 1 an expiry sweep (time only). out_o carries event words;
//   the final word of each input has last set.
//   A report goes through accept, match in all cells, update; its one
//   event is in the output register the cycle after the update, which waits
//   while a word still waits there. The next input is accepted right after that.
//   A sweep walks the slots from the top slot down, one per cycle while no
//   event waits on the output register, emitting each expired entry as it
//   passes it; it ends at the last expired slot, after 16 removals, or at
//   slot 0 with a "none gone" word. The single read bus of the cell row
//   makes the walk visit one slot at a time.
//   One output register decouples the sides: a new input is taken while a
//   word still waits there. When the receiver stalls, a pending event holds
//   the walk in place until the register frees up.
//   Reset empties the table and loads timeout 1000 ms and RSSI step 10 dB.
//   Registers: 0x0 gone_timeout_ms, 0x4 rssi_change_db over APB; write only
//   while idle.
// ----------------------------------------------------------------------------
module tag_presence_tracker
  import tpt_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tpt_in_if.sink            in_i,
  tpt_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW-1:0] TopIdx  = IdxW'(TABLE_DEPTH - 1);
  localparam logic [ResW-1:0] LastRes = ResW'(MaxResults - 1);

  logic [31:0] timeout_q;
  logic [7:0]  thr_q;
  logic        cfg_wr;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [ResW-1:0] n_q, n_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  req_t            req_q;
  logic [TABLE_DEPTH-1:0] match_q;

  logic [TABLE_DEPTH-1:0] match, expired, valid, first_free, tok_sel, rd_sel;
  logic [TABLE_DEPTH:0]   free_chain;
  entry_t                 rd_chain [TABLE_DEPTH+1];
  cell_ctl_t              ctl [TABLE_DEPTH];

  logic   hit, full, changed, pend_cur, pend_below, out_ok;
  logic   out_load, upd_fire, gone_fire, in_ready;
  logic [8:0] diff, mag;
  entry_t rd_ent;
  res_t   res, out_q;
  logic   out_valid_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= GoneTimeoutRst;
      thr_q     <= RssiChangeRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegGoneTimeout: timeout_q <= pwdata;
        RegRssiChange:  thr_q     <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegGoneTimeout: prdata = timeout_q;
      RegRssiChange:  prdata = {24'd0, thr_q};
    endcase
  end

  // ---------------- cell row ----------------
  assign free_chain[0] = 1'b0;
  assign rd_chain[0]   = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    tpt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl[g]),
      .req_i        (req_q),
      .timeout_i    (timeout_q),
      .sel_i        (rd_sel[g]),
      .free_below_i (free_chain[g]),
      .free_below_o (free_chain[g+1]),
      .first_free_o (first_free[g]),
      .rd_i         (rd_chain[g]),
      .rd_o         (rd_chain[g+1]),
      .match_o      (match[g]),
      .expired_o    (expired[g]),
      .valid_o      (valid[g])
    );
  end

  assign full   = ~free_chain[TABLE_DEPTH];
  assign rd_ent = rd_chain[TABLE_DEPTH];
  assign hit    = |match_q;

  // sweep token and expired entries below it
  always_comb begin
    pend_below = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tok_sel[i] = (idx_q == IdxW'(i));
      pend_below = pend_below | (expired[i] & (IdxW'(i) < idx_q));
    end
  end

  assign pend_cur = expired[idx_q];
  assign rd_sel   = (state_q == StSweep) ? tok_sel : match_q;

  // RSSI swing against the stored value
  assign diff    = {req_q.rssi[7], req_q.rssi} - {rd_ent.rssi[7], rd_ent.rssi};
  assign mag     = diff[8] ? (9'd0 - diff) : diff;
  assign changed = mag >= {1'b0, thr_q};

  // per-cell write controls
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ctl[i].ins      = upd_fire & ~hit & first_free[i];
      ctl[i].touch    = upd_fire & match_q[i];
      ctl[i].set_rssi = upd_fire & match_q[i] & changed;
      ctl[i].clr      = gone_fire & tok_sel[i];
    end
  end

  // ---------------- control ----------------
  assign out_ok = ~out_valid_q | out_o.ready;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    upd_fire  = 1'b0;
    gone_fire = 1'b0;
    in_ready  = 1'b0;
    res       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = in_i.mode ? StSweep : StLookup;
          idx_d   = TopIdx;
          n_d     = '0;
        end
      end
      StLookup: begin
        state_d = StUpdate;
      end
      StUpdate: begin
        if (out_ok) begin
          out_load      = 1'b1;
          upd_fire      = 1'b1;
          state_d       = StIdle;
          res.tag_upper = req_q.epc_upper;
          res.tag_lower = req_q.epc_lower;
          res.tag_bytes = req_q.epc_bytes;
          res.last      = 1'b1;
          priority if (hit) begin
            res.old_rssi = rd_ent.rssi;
            if (changed) begin
              res.ev       = EvRssiChanged;
              res.new_rssi = req_q.rssi;
            end else begin
              res.ev       = EvRefreshed;
              res.new_rssi = rd_ent.rssi;
            end
          end else if (full) begin
            res.ev       = EvDropped;
            res.old_rssi = req_q.rssi;
            res.new_rssi = req_q.rssi;
          end else begin
            res.ev       = EvArrived;
            res.old_rssi = req_q.rssi;
            res.new_rssi = req_q.rssi;
            cnt_d        = cnt_q + CntW'(1);
          end
          res.in_field = InFieldW'(cnt_d);
        end
      end
      StSweep: begin
        if (pend_cur) begin
          if (out_ok) begin
            out_load      = 1'b1;
            gone_fire     = 1'b1;
            cnt_d         = cnt_q - CntW'(1);
            n_d           = n_q + ResW'(1);
            res.ev        = EvGone;
            res.tag_upper = rd_ent.epc_upper;
            res.tag_lower = rd_ent.epc_lower;
            res.tag_bytes = rd_ent.epc_bytes;
            res.old_rssi  = rd_ent.rssi;
            res.new_rssi  = rd_ent.rssi;
            res.in_field  = InFieldW'(cnt_d);
            res.last      = (n_q == LastRes) | ~pend_below;
            if (res.last) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - IdxW'(1);
            end
          end
        end else if (idx_q == '0) begin
          // nothing expired anywhere
          if (out_ok) begin
            out_load     = 1'b1;
            res.ev       = EvNoneGone;
            res.in_field = InFieldW'(cnt_q);
            res.last     = 1'b1;
            state_d      = StIdle;
          end
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      cnt_q   <= cnt_d;
    end
  end

  // request latch and registered match vector
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      req_q.epc_upper <= in_i.epc_upper;
      req_q.epc_lower <= in_i.epc_lower;
      req_q.epc_bytes <= in_i.epc_bytes;
      req_q.rssi      <= in_i.rssi_dbm;
      req_q.now_ms    <= in_i.now_ms;
    end
    if (state_q == StLookup) begin
      match_q <= match;
    end
  end

  assign in_i.ready = in_ready;

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_q.ev;
  assign out_o.tag_upper = out_q.tag_upper;
  assign out_o.tag_lower = out_q.tag_lower;
  assign out_o.tag_bytes = out_q.tag_bytes;
  assign out_o.old_rssi  = out_q.old_rssi;
  assign out_o.new_rssi  = out_q.new_rssi;
  assign out_o.in_field  = out_q.in_field;
  assign out_o.last      = out_q.last;

`ifndef SYNTHESIS
  // a key lives in at most one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpdate |-> $onehot0(match_q))
    else $error("duplicate key in table");

  // fill count tracks the occupied slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'($countones(valid)))
    else $error("fill count out of step with slots");

  // a sweep never runs past its removal limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSweep |-> n_q < ResW'(MaxResults))
    else $error("sweep exceeded removal limit");

  // an event is never loaded over a word still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("output word overwritten");
`endif

endmodule

FILE: sim/tpt_event_checker.sv
// ----------------------------------------------------------------------------
// tpt_event_checker
// Watches the report/sweep channel, the event channel and the register port
// of the tag presence tracker. It keeps its own copy of the tag table, works
// out the event words that each accepted input word should cause, and
// compares every accepted event word with the oldest one still due.
// ----------------------------------------------------------------------------
module tpt_event_checker import tpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tpt_in_if                 in_i,
  tpt_out_if                out_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_cnt_o,
  output int                due_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers and tag table
  logic [31:0] timeout_q;
  logic [7:0]  step_db_q;
  logic        held_on    [TableDepth];
  entry_t      held_entry [TableDepth];
  logic [31:0] held_seen  [TableDepth];

  res_t        events_due_q[$];
  int          fails;

  function automatic logic [InFieldW-1:0] tags_held();
    int n;
    n = 0;
    for (int i = 0; i < TableDepth; i++) n += held_on[i];
    return n[InFieldW-1:0];
  endfunction

  // append one expected event word
  function automatic void add_due(input res_t r);
    events_due_q.insert(events_due_q.size(), r);
  endfunction

  // event word as seen after the table update
  function automatic res_t make_event(event_e ev, entry_t e, logic [7:0] new_rssi,
                                      logic last);
    res_t r;
    r.ev        = ev;
    r.tag_upper = e.epc_upper;
    r.tag_lower = e.epc_lower;
    r.tag_bytes = e.epc_bytes;
    r.old_rssi  = e.rssi;
    r.new_rssi  = new_rssi;
    r.in_field  = tags_held();
    r.last      = last;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t      rep;
    entry_t      e;
    res_t        want;
    res_t        got;
    int          d;
    int          n;
    int          free_slot;
    logic        hit;
    logic [31:0] age;
    if (!rst_ni) begin
      timeout_q = GoneTimeoutRst;
      step_db_q = RssiChangeRst;
      for (int i = 0; i < TableDepth; i++) held_on[i] = 1'b0;
      events_due_q.delete();
      fails = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          RegGoneTimeout: timeout_q = pwdata;
          RegRssiChange:  step_db_q = pwdata[7:0];
          default: ;
        endcase
      end

      // event word leaving the block
      if (out_i.valid && out_i.ready) begin
        got.ev        = event_e'(out_i.event_res);
        got.tag_upper = out_i.tag_upper;
        got.tag_lower = out_i.tag_lower;
        got.tag_bytes = out_i.tag_bytes;
        got.old_rssi  = out_i.old_rssi;
        got.new_rssi  = out_i.new_rssi;
        got.in_field  = out_i.in_field;
        got.last      = out_i.last;
        if (events_due_q.size() == 0) begin
          $display("%0t: event word %0h arrived with nothing expected", $time, got);
          fails++;
        end else begin
          want = events_due_q.pop_front();
          check_field("event", 64'(want.ev), 64'(got.ev));
          check_field("tag_upper", 64'(want.tag_upper), 64'(got.tag_upper));
          check_field("tag_lower", want.tag_lower, got.tag_lower);
          check_field("tag_bytes", 64'(want.tag_bytes), 64'(got.tag_bytes));
          check_field("old_rssi", 64'(want.old_rssi), 64'(got.old_rssi));
          check_field("new_rssi", 64'(want.new_rssi), 64'(got.new_rssi));
          check_field("in_field", 64'(want.in_field), 64'(got.in_field));
          check_field("last", 64'(want.last), 64'(got.last));
        end
      end

      // input word entering the block
      if (in_i.valid && in_i.ready) begin
        if (in_i.mode) begin
          // expiry sweep: top slot down, at most MaxResults removals
          n = 0;
          for (int i = TableDepth - 1; i >= 0; i--) begin
            age = in_i.now_ms - held_seen[i];
            if (n < MaxResults && held_on[i] && age >= timeout_q) begin
              held_on[i] = 1'b0;
              add_due(make_event(EvGone, held_entry[i], held_entry[i].rssi, 1'b0));
              n++;
            end
          end
          if (n == 0) begin
            add_due(make_event(EvNoneGone, '0, 8'd0, 1'b1));
          end else begin
            events_due_q[events_due_q.size() - 1].last = 1'b1;
          end
        end else begin
          // tag report: look up the full key among held slots
          rep.epc_upper = in_i.epc_upper;
          rep.epc_lower = in_i.epc_lower;
          rep.epc_bytes = in_i.epc_bytes;
          rep.rssi      = in_i.rssi_dbm;
          hit = 1'b0;
          free_slot = -1;
          for (int i = 0; i < TableDepth; i++) begin
            if (!hit && held_on[i] && held_entry[i].epc_upper == rep.epc_upper &&
                held_entry[i].epc_lower == rep.epc_lower &&
                held_entry[i].epc_bytes == rep.epc_bytes) begin
              hit = 1'b1;
              e = held_entry[i];
              d = int'($signed(rep.rssi)) - int'($signed(e.rssi));
              if (d < 0) d = -d;
              held_seen[i] = in_i.now_ms;
              if (d >= int'(step_db_q)) begin
                held_entry[i].rssi = rep.rssi;
                add_due(make_event(EvRssiChanged, e, rep.rssi, 1'b1));
              end else begin
                add_due(make_event(EvRefreshed, e, e.rssi, 1'b1));
              end
            end
          end
          if (!hit) begin
            for (int i = 0; i < TableDepth; i++)
              if (free_slot < 0 && !held_on[i]) free_slot = i;
            if (free_slot < 0) begin
              add_due(make_event(EvDropped, rep, rep.rssi, 1'b1));
            end else begin
              held_on[free_slot]    = 1'b1;
              held_entry[free_slot] = rep;
              held_seen[free_slot]  = in_i.now_ms;
              add_due(make_event(EvArrived, rep, rep.rssi, 1'b1));
            end
          end
        end
      end
    end
    fail_cnt_o <= fails;
    due_cnt_o  <= events_due_q.size();
  end

endmodule

FILE: sim/tb_tag_presence_tracker.sv
// ----------------------------------------------------------------------------
// tb_tag_presence_tracker
// Drives tag reports and expiry sweeps into the tag presence tracker: a
// directed pass over key matching, RSSI thresholds, a full table, wrapping
// time and sweep boundaries, then random phases under several register
// settings. The receiver stalls on its own pattern and once holds off long
// enough to back the block up. Checking is done by tpt_event_checker.
// ----------------------------------------------------------------------------
module tb_tag_presence_tracker import tpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PoolSize     = 20;
  localparam int ItemsPerSet  = 36;
  localparam int NumSettings  = 5;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 20;
  localparam int QuietLimit   = 2000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_cnt;
  int                due_cnt;

  tpt_in_if  in_ch ();
  tpt_out_if out_ch ();

  tag_presence_tracker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tpt_event_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_cnt_o(fail_cnt),
    .due_cnt_o (due_cnt)
  );

  always #5ns clk_i = ~clk_i;

  // receiver: changing stall styles, plus one long hold-off on request
  logic hold_go;
  logic hold_done;
  int   hold_left;
  int   stall_style;
  int   style_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      style_left = 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 80);
      end
      style_left--;
      case (stall_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((style_left % 3) != 0);
      endcase
    end
  end

  // watchdog on cycles with no word moving
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_tag_presence_tracker failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sender state
  int          burst_left = 0;
  logic [31:0] clock_ms;
  logic [31:0] cur_timeout;
  logic [7:0]  cur_step;
  logic [31:0] pool_upper [PoolSize];
  logic [63:0] pool_lower [PoolSize];
  logic [3:0]  pool_bytes [PoolSize];
  logic [7:0]  pool_rssi  [PoolSize];

  // offer one word in bursts with random gaps; returns at its accepting edge
  task automatic send_word(input logic mode, input logic [31:0] up, input logic [63:0] lo,
                           input logic [3:0] nb, input logic [7:0] rssi,
                           input logic [31:0] now);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.epc_upper <= up;
    in_ch.epc_lower <= lo;
    in_ch.epc_bytes <= nb;
    in_ch.rssi_dbm  <= rssi;
    in_ch.now_ms    <= now;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop offering and wait until every due event word has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (due_cnt != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] set_timeout [NumSettings];
    logic [7:0]  set_step    [NumSettings];
    logic [31:0] span;
    logic [7:0]  rssi;
    int          k;
    int          r;

    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    hold_go         <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= 1'b0;
    in_ch.epc_upper <= '0;
    in_ch.epc_lower <= '0;
    in_ch.epc_bytes <= '0;
    in_ch.rssi_dbm  <= '0;
    in_ch.now_ms    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: key matching and RSSI thresholds at reset settings
    send_word(1'b0, '1, '1, 4'd12, 8'd127, 32'hFFFF_FF00);     // arrives
    send_word(1'b0, '1, '1, 4'd12, 8'd118, 32'hFFFF_FF10);     // swing 9: refresh only
    send_word(1'b0, '1, '1, 4'd12, 8'd117, 32'hFFFF_FF18);     // swing exactly 10
    send_word(1'b0, '0, '0, 4'd0, 8'h80, 32'hFFFF_FF20);       // all-zero key
    send_word(1'b0, '0, '0, 4'd15, 8'h80, 32'hFFFF_FF20);      // length above 12, own key
    send_word(1'b0, '0, '0, 4'd0, 8'd127, 32'hFFFF_FF30);      // full-scale swing
    send_word(1'b0, 32'hA5A5_0000, 64'hDEAD_BEEF_0000_0001, 4'd4, 8'hFF,
              32'hFFFF_FF40);                                   // bits past the length
    send_word(1'b1, $urandom, {$urandom, $urandom}, 4'($urandom), 8'($urandom),
              32'h0000_0100);                                   // nothing old enough
    for (int i = 0; i < 12; i++)
      send_word(1'b0, 32'(i + 1), {$urandom, $urandom}, 4'(i), 8'(i * 20), 32'h0000_0180);
    send_word(1'b0, 32'h1234_5678, {$urandom, $urandom}, 4'd8, 8'd5, 32'h0000_0190);
                                                                // table full: dropped
    send_word(1'b1, '0, '0, 4'd0, 8'd0, 32'h0000_03F0);         // wrapped ages expire
    send_word(1'b1, '1, '1, 4'hF, 8'hFF, 32'h0000_0568);        // age equal to timeout
    send_word(1'b1, '0, '0, 4'd0, 8'd0, 32'h0000_0568);         // empty table

    // register settings for the random phases, extremes included
    set_timeout[0] = 32'd1;          set_step[0] = 8'd0;
    set_timeout[1] = 32'hFFFF_FFFF;  set_step[1] = 8'd255;
    set_timeout[2] = 32'd0;          set_step[2] = 8'd10;
    set_timeout[3] = 32'd50;         set_step[3] = 8'd3;
    set_timeout[4] = $urandom_range(100, 5000);
    set_step[4]    = $urandom_range(0, 255);

    for (int i = 0; i < PoolSize; i++) begin
      pool_upper[i] = $urandom;
      pool_lower[i] = {$urandom, $urandom};
      pool_bytes[i] = $urandom_range(0, 15);
      pool_rssi[i]  = $urandom;
    end
    clock_ms = $urandom;

    for (int p = 0; p < NumSettings; p++) begin
      wait_drained();
      cur_timeout = set_timeout[p];
      cur_step    = set_step[p];

      // both registers, setup then access phase each
      for (int g = 0; g < 2; g++) begin
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {(g == 0) ? RegGoneTimeout : RegRssiChange, 2'b00};
        pwdata  <= (g == 0) ? cur_timeout : {24'd0, cur_step};
        @(posedge clk_i);
        penable <= 1'b1;
        do @(posedge clk_i); while (!pready);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);

      if (cur_timeout == 0 || cur_timeout > 32'd12000) span = 32'd3000;
      else span = cur_timeout / 4 + 1;

      // long receiver hold-off while the sender keeps pushing
      if (p == 3) begin
        hold_go <= 1'b1;
        burst_left = 30;
      end

      // largest possible age: sweep one tick before the report time
      send_word(1'b0, pool_upper[0], pool_lower[0], pool_bytes[0], pool_rssi[0], clock_ms);
      send_word(1'b1, $urandom, {$urandom, $urandom}, 4'($urandom), 8'($urandom),
                clock_ms - 32'd1);

      for (int n = 0; n < ItemsPerSet; n++) begin
        r = $urandom_range(0, 9);
        if (r == 0) clock_ms += $urandom;
        else if (r > 2) clock_ms += $urandom_range(0, span);
        if ($urandom_range(0, 4) == 0) begin
          send_word(1'b1, $urandom, {$urandom, $urandom}, 4'($urandom), 8'($urandom),
                    clock_ms);
        end else begin
          k = $urandom_range(0, PoolSize - 1);
          if ($urandom_range(0, 3) == 0) begin
            pool_upper[k] = $urandom;
            pool_lower[k] = {$urandom, $urandom};
            pool_bytes[k] = $urandom_range(0, 15);
          end
          // either any RSSI or one just around the change threshold
          if ($urandom_range(0, 1) == 0) rssi = $urandom;
          else rssi = 8'(int'(pool_rssi[k]) + int'($urandom_range(0, 2 * cur_step + 2))
                         - int'(cur_step) - 1);
          pool_rssi[k] = rssi;
          send_word(1'b0, pool_upper[k], pool_lower[k], pool_bytes[k], rssi, clock_ms);
        end
      end
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("tb_tag_presence_tracker passed");
    end else begin
      $display("tb_tag_presence_tracker failed");
    end
    $finish;
  end

endmodule
